// ----- sv/encds_pkg.sv -----
// ----------------------------------------------------------------------------
// encds_pkg
// shared widths, stream layout and the per-motor state record
// ----------------------------------------------------------------------------
package encds_pkg;

  localparam int SAMPLE_W   = 16;  // raw encoder counter
  localparam int DELTA_W    = 16;  // signed tick difference
  localparam int COUNT_W    = 32;  // wrapping position count
  localparam int AVG_W      = 18;  // window mean, two fraction bits
  localparam int SUM_W      = 20;  // window sum, wide enough for sixteen deltas

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 72;  // 66 payload bits padded to whole bytes
  localparam int OUT_USER_W = 1;
  localparam int OUT_PAD_W  = OUT_DATA_W - DELTA_W - COUNT_W - AVG_W;

  // one entry of the per-motor state memory
  typedef struct packed {
    logic [SAMPLE_W-1:0]     prev;
    logic [COUNT_W-1:0]      total;
    logic signed [SUM_W-1:0] sum;
  } motor_state_t;

  localparam int STATE_W = $bits(motor_state_t);

endpackage

// ----- sv/encds_ram.sv -----
// ----------------------------------------------------------------------------
// encds_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module encds_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/encds_avg.sv -----
// ----------------------------------------------------------------------------
// encds_avg
// scales the window sum to the mean with two fraction bits, floor rounding
// ----------------------------------------------------------------------------
module encds_avg #(
  parameter int WINDOW = 4
) (
  input  logic signed [encds_pkg::SUM_W-1:0] sum_i,
  output logic [encds_pkg::AVG_W-1:0]        avg_o
);

  import encds_pkg::*;

  // bias the scaled sum so the divide works on a non-negative value
  localparam int X_W   = SUM_W + 2;
  localparam int DIV_S = X_W + 4;
  localparam int Bias  = 2 ** (AVG_W - 1);
  localparam logic [X_W-1:0] Offset = X_W'(WINDOW * Bias);
  localparam bit PowTwo = ((WINDOW & (WINDOW - 1)) == 0);

  logic [X_W-1:0]   biased;
  logic [AVG_W-1:0] quot;

  assign biased = {sum_i, 2'b00} + Offset;

  if (PowTwo) begin : g_shift
    localparam int LogW = $clog2(WINDOW);
    assign quot = AVG_W'(biased >> LogW);
  end else begin : g_mult
    // reciprocal multiply, exact for every biased value below 2**X_W
    localparam logic [DIV_S-1:0] DivM = DIV_S'((2 ** DIV_S + WINDOW - 1) / WINDOW);
    logic [X_W+DIV_S-1:0] prod;
    assign prod = (X_W + DIV_S)'(biased) * (X_W + DIV_S)'(DivM);
    assign quot = prod[DIV_S +: AVG_W];
  end

  assign avg_o = quot - AVG_W'(Bias);

endmodule

// ----- sv/encoder_delta_speed_average.sv -----
// ----------------------------------------------------------------------------
// encoder_delta_speed_average
// per-motor encoder delta, wrapping position and moving-average speed
// ----------------------------------------------------------------------------
// Takes one encoder counter sample per beat, tagged with its motor number on
// in_tuser, and returns one result beat per sample: the signed tick delta
// against that motor's previous sample, the wrapping 32-bit position and the
// mean of the last WINDOW deltas with two fraction bits. A new sample is taken
// every cycle while stage 1 or the output register is free or the result is
// taken. Each sample passes the registered state memory read, then stage 1,
// which updates the motor's entry and writes it back, then the output register;
// a forwarding register lets one motor's samples go back to back. The
// window mean is kept as a running sum, so one read of the oldest ring entry
// per sample is enough. Samples whose motor number is not below MOTORS are
// accepted and dropped without any result. All per-motor state reads as zero
// right after reset through valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
module encoder_delta_speed_average #(
  parameter int MOTORS = 2,
  parameter int WINDOW = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [encds_pkg::IN_DATA_W-1:0]   in_tdata,   // [15:0] counter_sample
  input  logic [encds_pkg::IN_USER_W-1:0]   in_tuser,   // [0] motor_number
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [encds_pkg::OUT_DATA_W-1:0]  out_tdata,  // [15:0] tick_delta,
                                                        // [47:16] absolute_count,
                                                        // [65:48] speed_average_q2,
                                                        // [71:66] zero
  output logic [encds_pkg::OUT_USER_W-1:0]  out_tuser   // [0] motor_tag
);

  import encds_pkg::*;

  localparam int MIDX_W      = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int STATE_DEPTH = 2 ** MIDX_W;
  localparam int RING_AW     = MIDX_W + SLOT_W;
  localparam int RING_DEPTH  = 2 ** RING_AW;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // --------------------------------------------------------------------------
  // accept side
  // --------------------------------------------------------------------------
  logic              in_beat;
  logic              in_range;
  logic              launch;
  logic [MIDX_W-1:0] in_idx;
  logic [RING_AW-1:0] in_ring_addr;

  // stage 1 (memory data valid) and output register
  logic               s1_v_r, s1_v_nxt;
  logic [MIDX_W-1:0]  s1_idx_r;
  logic [SLOT_W-1:0]  s1_slot_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic               s1_adv;

  logic               out_v_r, out_v_nxt;
  logic [OUT_USER_W-1:0] out_tag_r;
  logic [DELTA_W-1:0] out_delta_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [AVG_W-1:0]   out_avg_r;

  // next ring slot per motor, kept in flops so the ring address is known
  // at accept time
  logic [SLOT_W-1:0]  slot_r [STATE_DEPTH];
  logic [SLOT_W-1:0]  slot_cur;
  logic [SLOT_W-1:0]  slot_nxt;

  assign in_beat      = in_tvalid && in_tready;
  assign in_range     = (32'(in_tuser) < 32'(MOTORS));
  assign launch       = in_beat && in_range;
  assign in_idx       = MIDX_W'(in_tuser);
  assign slot_cur     = slot_r[in_idx];
  assign slot_nxt     = (slot_cur == SLOT_LAST) ? '0 : slot_cur + 1'b1;
  assign in_ring_addr = {in_idx, slot_cur};

  // stage 1 moves on when the output register is free or being drained
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STATE_DEPTH; i++) begin
        slot_r[i] <= '0;
      end
    end else if (launch) begin
      slot_r[in_idx] <= slot_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // state and ring memories
  // --------------------------------------------------------------------------
  motor_state_t        st_rdata;
  motor_state_t        st_wdata;
  logic [DELTA_W-1:0]  ring_rdata;
  logic [RING_AW-1:0]  s1_ring_addr;
  logic [DELTA_W-1:0]  delta;

  assign s1_ring_addr = {s1_idx_r, s1_slot_r};

  encds_ram #(
    .WIDTH (STATE_W),
    .DEPTH (STATE_DEPTH)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_idx_r),
    .wr_data (st_wdata),
    .rd_en   (launch),
    .rd_addr (in_idx),
    .rd_data (st_rdata)
  );

  encds_ram #(
    .WIDTH (DELTA_W),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_ring_addr),
    .wr_data (delta),
    .rd_en   (launch),
    .rd_addr (in_ring_addr),
    .rd_data (ring_rdata)
  );

  // valid bits: an entry never written reads as zero
  logic [STATE_DEPTH-1:0] st_vld_r;
  logic [RING_DEPTH-1:0]  ring_vld_r;

  // last write, forwarded to a read issued on the same edge
  logic               fwd_v_r;
  logic [MIDX_W-1:0]  fwd_idx_r;
  motor_state_t       fwd_st_r;
  logic [RING_AW-1:0] fwd_ring_addr_r;
  logic [DELTA_W-1:0] fwd_delta_r;

  // --------------------------------------------------------------------------
  // read-modify-write in stage 1
  // --------------------------------------------------------------------------
  motor_state_t       cur_st;
  logic [DELTA_W-1:0] old_delta;
  logic [AVG_W-1:0]   avg_s1;

  always_comb begin
    if (fwd_v_r && (fwd_idx_r == s1_idx_r)) begin
      cur_st = fwd_st_r;
    end else if (st_vld_r[s1_idx_r]) begin
      cur_st = st_rdata;
    end else begin
      cur_st = '0;
    end

    if (fwd_v_r && (fwd_ring_addr_r == s1_ring_addr)) begin
      old_delta = fwd_delta_r;
    end else if (ring_vld_r[s1_ring_addr]) begin
      old_delta = ring_rdata;
    end else begin
      old_delta = '0;
    end

    // wrap-around difference, read as two's complement
    delta = s1_sample_r - cur_st.prev;

    st_wdata.prev  = s1_sample_r;
    st_wdata.total = cur_st.total
                   + {{(COUNT_W - DELTA_W){delta[DELTA_W-1]}}, delta};
    // running window sum: add the new delta, drop the one it replaces
    st_wdata.sum   = cur_st.sum
                   + {{(SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta}
                   - {{(SUM_W - DELTA_W){old_delta[DELTA_W-1]}}, old_delta};
  end

  encds_avg #(
    .WINDOW (WINDOW)
  ) u_avg (
    .sum_i (st_wdata.sum),
    .avg_o (avg_s1)
  );

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_comb begin
    if (in_beat) begin
      s1_v_nxt = in_range;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end

    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      fwd_v_r    <= 1'b0;
      st_vld_r   <= '0;
      ring_vld_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_adv) begin
        fwd_v_r                  <= 1'b1;
        st_vld_r[s1_idx_r]       <= 1'b1;
        ring_vld_r[s1_ring_addr] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (launch) begin
      s1_idx_r    <= in_idx;
      s1_slot_r   <= slot_cur;
      s1_sample_r <= in_tdata[SAMPLE_W-1:0];
    end
    if (s1_adv) begin
      fwd_idx_r       <= s1_idx_r;
      fwd_st_r        <= st_wdata;
      fwd_ring_addr_r <= s1_ring_addr;
      fwd_delta_r     <= delta;

      out_tag_r   <= OUT_USER_W'(s1_idx_r);
      out_delta_r <= delta;
      out_count_r <= st_wdata.total;
      out_avg_r   <= avg_s1;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_tag_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_avg_r, out_count_r, out_delta_r};

endmodule

// ----- sv/encds_checker.sv -----
// ----------------------------------------------------------------------------
// encds_checker
// port-level checks on the encoder speed block, bound to the top level
// ----------------------------------------------------------------------------
module encds_checker #(
  parameter int MOTORS = 2
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [encds_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [encds_pkg::OUT_USER_W-1:0]  out_tuser
);

  logic out_beat;

  assign out_beat = out_tvalid && out_tready;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // input side never waits while the result register can drain
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with a free result slot");

  // results only for motors that exist
  a_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tuser) < 32'(MOTORS)))
    else $error("result tagged with a motor out of range");

  // back-to-back beats of one motor: position moves by exactly the delta
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && $past(out_beat) && (out_tuser == $past(out_tuser))
    |-> out_tdata[47:16] == $past(out_tdata[47:16])
                            + {{16{out_tdata[15]}}, out_tdata[15:0]})
    else $error("position does not follow delta");

endmodule

bind encoder_delta_speed_average encds_checker #(.MOTORS(MOTORS)) u_encds_checker (.*);
